FILE: rtl/ray_nearest_sphere_hit_macros.svh
// Assertion macros shared by the nearest sphere hit RTL
`ifndef RAY_NEAREST_SPHERE_HIT_MACROS_SVH
`define RAY_NEAREST_SPHERE_HIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RNSH_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("rnsh assertion failed");
`define RNSH_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("rnsh assertion failed");
`else
`define RNSH_ASSERT_IMP(lbl, clk, rstn, a, c)
`define RNSH_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

FILE: rtl/rnsh_pkg.sv
// Shared types and constants of the nearest sphere hit block
package rnsh_pkg;
    localparam int INDEX_BITS_DEF = 16;
    localparam int FIFO_DEPTH     = 4;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;

    localparam logic [CFG_AW-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DIR_Z = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_MAXD  = 3'd6;

    typedef struct packed {
        logic [31:0] org_x;
        logic [31:0] org_y;
        logic [31:0] org_z;
        logic [17:0] dir_x;
        logic [17:0] dir_y;
        logic [17:0] dir_z;
        logic [30:0] max_d;
    } t_cfg;

    typedef struct packed {
        logic        cand;
        logic        last;
        logic [30:0] proj;
        logic [15:0] idx;
        logic [31:0] pt_x;
        logic [31:0] pt_y;
        logic [31:0] pt_z;
        logic [16:0] off_x;
        logic [16:0] off_y;
        logic [16:0] off_z;
    } t_entry;
endpackage

FILE: rtl/ray_nearest_sphere_hit.sv
// Top level: nearest ray-sphere hit over a stream of body centres
// Each body word passes the front end's multiply, dot, projection, point and
// square states (one word at a time); a four-entry queue feeds the back end.
// After the last body the normal is computed (25-step square root, three
// 41-step divisions) before the result word.
// Synchronous active-low reset clears control state and loads register defaults.
module ray_nearest_sphere_hit #(
    parameter int INDEX_BITS = rnsh_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rnsh_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [rnsh_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,  // body_x, body_y, body_z
    input  logic                          s_axis_tuser,  // body_present
    input  logic                          s_axis_tlast,  // last_body
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z, hit_distance, hit_index, pad
    output logic [199:0]                  m_axis_tdata,
    output logic                          m_axis_tuser   // hit
);
    import rnsh_pkg::*;

    t_cfg        r_cfg;
    t_entry      w_fe, w_be;
    logic        w_push, w_pop, w_full, w_empty;
    logic [95:0] w_point;
    logic [53:0] w_normal;
    logic [30:0] w_dist;
    logic [15:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.org_x <= '0;
            r_cfg.org_y <= '0;
            r_cfg.org_z <= '0;
            r_cfg.dir_x <= 18'd65536;
            r_cfg.dir_y <= '0;
            r_cfg.dir_z <= '0;
            r_cfg.max_d <= 31'h7fffffff;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ORG_X: r_cfg.org_x <= i_cfg_wdata;
                CFG_ORG_Y: r_cfg.org_y <= i_cfg_wdata;
                CFG_ORG_Z: r_cfg.org_z <= i_cfg_wdata;
                CFG_DIR_X: r_cfg.dir_x <= i_cfg_wdata[17:0];
                CFG_DIR_Y: r_cfg.dir_y <= i_cfg_wdata[17:0];
                CFG_DIR_Z: r_cfg.dir_z <= i_cfg_wdata[17:0];
                CFG_MAXD:  r_cfg.max_d <= i_cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    rnsh_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_body    (s_axis_tdata),
        .i_present (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_entry   (w_fe)
    );

    rnsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_fe),
        .i_pop   (w_pop),
        .o_entry (w_be),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rnsh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_max_d  (r_cfg.max_d),
        .i_empty  (w_empty),
        .i_entry  (w_be),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_hit    (m_axis_tuser),
        .o_point  (w_point),
        .o_normal (w_normal),
        .o_dist   (w_dist),
        .o_idx    (w_idx)
    );

    assign m_axis_tdata = {3'b0, w_idx, w_dist, w_normal, w_point};
endmodule

FILE: rtl/rnsh_front.sv
// Front end: accept a body word and test it against the ray
module rnsh_front #(
    parameter int INDEX_BITS = rnsh_pkg::INDEX_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rnsh_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [95:0]     i_body,
    input  logic            i_present,
    input  logic            i_last,
    input  logic            i_full,
    output logic            o_push,
    output rnsh_pkg::t_entry o_entry
);
    import rnsh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DOT  = 3'd2;
    localparam logic [2:0] ST_PMUL = 3'd3;
    localparam logic [2:0] ST_PT   = 3'd4;
    localparam logic [2:0] ST_SQ   = 3'd5;

    logic [2:0]            r_st, n_st;
    logic [INDEX_BITS-1:0] r_cnt;
    logic [15:0]           r_idx;
    logic                  r_pres, r_last, r_inr;
    logic signed [31:0]    r_body [3];
    logic signed [32:0]    r_d    [3];
    logic signed [50:0]    r_p    [3];
    logic signed [36:0]    r_proj;
    logic signed [49:0]    r_q    [3];
    logic signed [33:0]    r_pt   [3];
    logic signed [34:0]    r_off  [3];

    logic signed [31:0] w_org [3];
    logic signed [17:0] w_dir [3];
    logic signed [52:0] w_dot;
    logic signed [36:0] w_proj;
    logic signed [33:0] w_pt  [3];
    logic [31:0]        w_sat [3];
    logic               w_near;
    logic [33:0]        w_sq;
    logic [16:0]        w_o17 [3];
    logic signed [33:0] w_ox  [3];

    always_comb begin
        w_org[0] = $signed(i_cfg.org_x);
        w_org[1] = $signed(i_cfg.org_y);
        w_org[2] = $signed(i_cfg.org_z);
        w_dir[0] = $signed(i_cfg.dir_x);
        w_dir[1] = $signed(i_cfg.dir_y);
        w_dir[2] = $signed(i_cfg.dir_z);
        w_dot = 53'(r_p[0]) + 53'(r_p[1]) + 53'(r_p[2]);
        w_proj = 37'(w_dot >>> 16);
        w_near = 1'b1;
        w_sq = '0;
        for (int k = 0; k < 3; k++) begin
            w_pt[k] = 34'(w_org[k]) + 34'(r_q[k] >>> 16);
            if (r_pt[k] > 34'sh07fffffff) begin
                w_sat[k] = 32'h7fffffff;
            end else if (r_pt[k] < -34'sh080000000) begin
                w_sat[k] = 32'h80000000;
            end else begin
                w_sat[k] = r_pt[k][31:0];
            end
            if (r_off[k] > 35'sd32768 || r_off[k] < -35'sd32768) begin
                w_near = 1'b0;
            end
            w_o17[k] = r_off[k][16:0];
            w_ox[k] = 34'($signed(w_o17[k]));
            w_sq = w_sq + unsigned'(w_ox[k] * w_ox[k]);
        end
    end

    assign o_ready = (r_st == ST_IDLE);
    assign o_push  = (r_st == ST_SQ) && !i_full;

    always_comb begin
        o_entry.cand  = r_pres && r_inr && w_near && (w_sq <= 34'h040000000);
        o_entry.last  = r_last;
        o_entry.proj  = r_proj[30:0];
        o_entry.idx   = r_idx;
        o_entry.pt_x  = w_sat[0];
        o_entry.pt_y  = w_sat[1];
        o_entry.pt_z  = w_sat[2];
        o_entry.off_x = w_o17[0];
        o_entry.off_y = w_o17[1];
        o_entry.off_z = w_o17[2];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_MUL;
            ST_MUL:  n_st = ST_DOT;
            ST_DOT:  n_st = ST_PMUL;
            ST_PMUL: n_st = ST_PT;
            ST_PT:   n_st = ST_SQ;
            ST_SQ:   if (!i_full) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_IDLE && i_valid) begin
                r_cnt <= i_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_pres <= i_present;
                r_last <= i_last;
                r_idx  <= 16'(r_cnt);
                for (int k = 0; k < 3; k++) begin
                    r_body[k] <= $signed(i_body[32*k +: 32]);
                    r_d[k] <= 33'($signed(i_body[32*k +: 32])) - 33'(w_org[k]);
                end
            end
            ST_MUL: begin
                for (int k = 0; k < 3; k++) r_p[k] <= r_d[k] * w_dir[k];
            end
            ST_DOT: begin
                r_proj <= w_proj;
                r_inr  <= (w_proj >= 37'sd0) && (w_proj <= $signed({6'b0, i_cfg.max_d}));
            end
            ST_PMUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_q[k] <= w_dir[k] * $signed({1'b0, r_proj[30:0]});
                end
            end
            ST_PT: begin
                for (int k = 0; k < 3; k++) begin
                    r_pt[k]  <= w_pt[k];
                    r_off[k] <= 35'(w_pt[k]) - 35'(r_body[k]);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

FILE: rtl/rnsh_fifo.sv
// Short queue between front and back ends
`include "ray_nearest_sphere_hit_macros.svh"
module rnsh_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rnsh_pkg::t_entry i_entry,
    input  logic             i_pop,
    output rnsh_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);
    import rnsh_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_entry        r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    `RNSH_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (PW+1)'(FIFO_DEPTH))
    `RNSH_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `RNSH_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
endmodule

FILE: rtl/rnsh_norm.sv
// Unit normal of the nearest hit: square root and three divisions
module rnsh_norm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_off [3],
    output logic        o_done,
    output logic [17:0] o_nrm [3]
);
    import rnsh_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SUM   = 3'd1;
    localparam logic [2:0] N_SQRT  = 3'd2;
    localparam logic [2:0] N_DINIT = 3'd3;
    localparam logic [2:0] N_DIV   = 3'd4;
    localparam logic [2:0] N_STORE = 3'd5;

    logic [2:0]  r_st;
    logic [5:0]  r_cnt;
    logic [1:0]  r_axis;
    logic        r_zero;
    logic [49:0] r_n, r_res, r_bit;
    logic [40:0] r_num;
    logic [25:0] r_rem;

    logic [34:0] w_s;
    logic signed [34:0] w_sx [3];
    logic [49:0] w_trial;
    logic [25:0] w_rt;
    logic [24:0] w_len;
    logic [16:0] w_mag;
    logic [17:0] w_q;
    logic        w_neg;

    always_comb begin
        w_s = '0;
        for (int k = 0; k < 3; k++) begin
            w_sx[k] = 35'($signed(i_off[k]));
            w_s = w_s + unsigned'(w_sx[k] * w_sx[k]);
        end
        w_trial = r_res + r_bit;
        w_len   = r_res[24:0];
        w_rt    = {r_rem[24:0], r_num[40]};
        w_neg   = i_off[r_axis][16];
        w_mag   = w_neg ? 17'(-$signed(i_off[r_axis])) : i_off[r_axis];
        w_q     = (r_num > 41'd65536) ? 18'd65536 : r_num[17:0];
    end

    assign o_done = (r_st == N_STORE) && (r_axis == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= N_IDLE;
        end else begin
            case (r_st)
                N_IDLE: if (i_start) r_st <= N_SUM;
                N_SUM:  r_st <= N_SQRT;
                N_SQRT: if (r_cnt == 6'd24) r_st <= N_DINIT;
                N_DINIT: r_st <= N_DIV;
                N_DIV:  if (r_cnt == 6'd40) r_st <= N_STORE;
                N_STORE: r_st <= (r_axis == 2'd2) ? N_IDLE : N_DINIT;
                default: r_st <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            N_SUM: begin
                r_n    <= {w_s[33:0], 16'b0};
                r_res  <= '0;
                r_bit  <= 50'd1 << 48;
                r_zero <= (w_s == '0);
                r_cnt  <= '0;
                r_axis <= '0;
            end
            N_SQRT: begin
                if (r_n >= w_trial) begin
                    r_n   <= r_n - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            N_DINIT: begin
                r_num <= {w_mag, 24'b0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            N_DIV: begin
                if (w_rt >= 26'(w_len)) begin
                    r_rem <= w_rt - 26'(w_len);
                    r_num <= {r_num[39:0], 1'b1};
                end else begin
                    r_rem <= w_rt;
                    r_num <= {r_num[39:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            N_STORE: begin
                o_nrm[r_axis] <= r_zero ? '0 : (w_neg ? 18'(-w_q) : w_q);
                r_axis <= r_axis + 1'b1;
            end
            default: begin
            end
        endcase
    end
endmodule

FILE: rtl/rnsh_back.sv
// Back end: keep the nearest hit and emit the result word
module rnsh_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [30:0]      i_max_d,
    input  logic             i_empty,
    input  rnsh_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic [95:0]      o_point,
    output logic [53:0]      o_normal,
    output logic [30:0]      o_dist,
    output logic [15:0]      o_idx
);
    import rnsh_pkg::*;

    localparam logic [1:0] B_RUN  = 2'd0;
    localparam logic [1:0] B_NORM = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]  r_st;
    logic        r_found, r_start;
    logic [30:0] r_dist;
    logic [15:0] r_idx;
    logic [31:0] r_pt  [3];
    logic [16:0] r_off [3];
    logic [17:0] w_nrm [3];
    logic        w_done, w_better;

    rnsh_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_off   (r_off),
        .o_done  (w_done),
        .o_nrm   (w_nrm)
    );

    assign o_pop    = (r_st == B_RUN) && !i_empty;
    assign w_better = i_entry.cand && (i_entry.proj < (r_found ? r_dist : i_max_d));
    assign o_valid  = (r_st == B_OUT);
    assign o_hit    = r_found;
    assign o_point  = {r_pt[2], r_pt[1], r_pt[0]};
    assign o_normal = {w_nrm[2], w_nrm[1], w_nrm[0]};
    assign o_dist   = r_found ? r_dist : '0;
    assign o_idx    = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_RUN;
            r_start <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pt[k]  <= '0;
                r_off[k] <= '0;
            end
        end else begin
            r_start <= 1'b0;
            case (r_st)
                B_RUN: begin
                    if (o_pop) begin
                        if (w_better) begin
                            r_found  <= 1'b1;
                            r_dist   <= i_entry.proj;
                            r_idx    <= i_entry.idx;
                            r_pt[0]  <= i_entry.pt_x;
                            r_pt[1]  <= i_entry.pt_y;
                            r_pt[2]  <= i_entry.pt_z;
                            r_off[0] <= i_entry.off_x;
                            r_off[1] <= i_entry.off_y;
                            r_off[2] <= i_entry.off_z;
                        end
                        if (i_entry.last) begin
                            r_st    <= B_NORM;
                            r_start <= 1'b1;
                        end
                    end
                end
                B_NORM: if (w_done) r_st <= B_OUT;
                B_OUT: begin
                    if (i_ready) begin
                        r_st    <= B_RUN;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_pt[k]  <= '0;
                            r_off[k] <= '0;
                        end
                    end
                end
                default: r_st <= B_RUN;
            endcase
        end
    end
endmodule
